### sv/ceu_pkg.sv
// Shared types, constants and the UTF-8 encoder for the cell text extractor.
// Used by ceu_front, ceu_back and the top level; depends on nothing.
`default_nettype none

package ceu_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned COL_W  = 17;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KEPT_W = 24;

  localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

  localparam logic [CP_W-1:0] CP_EMPTY = 21'h000000;
  localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
  localparam logic [CP_W-1:0] CP_LIM1  = 21'h000080;
  localparam logic [CP_W-1:0] CP_LIM2  = 21'h000800;
  localparam logic [CP_W-1:0] CP_LIM3  = 21'h010000;

  localparam logic [BYTE_W-1:0] LEAD2    = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4    = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_TAG = 8'h80;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;  // element 0 goes out first
    logic [1:0]             last;   // index of the final byte
  } utf8_t;

  // One queued job: either a cell's byte group or a closing line-end beat.
  typedef struct packed {
    logic                   line_end;
    logic [1:0]             last;
    logic [3:0][BYTE_W-1:0] bytes;
    logic [POS_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [KEPT_W-1:0]      kept;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp_in);
    logic [CP_W-1:0] cp;
    utf8_t           res;
    cp        = (cp_in == CP_EMPTY) ? CP_SPACE : cp_in;
    res.bytes = '0;
    if (cp < CP_LIM1) begin
      res.bytes[0] = {1'b0, cp[6:0]};
      res.last     = 2'd0;
    end else if (cp < CP_LIM2) begin
      res.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
      res.bytes[1] = CONT_TAG | {2'b00, cp[5:0]};
      res.last     = 2'd1;
    end else if (cp < CP_LIM3) begin
      res.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
      res.bytes[1] = CONT_TAG | {2'b00, cp[11:6]};
      res.bytes[2] = CONT_TAG | {2'b00, cp[5:0]};
      res.last     = 2'd2;
    end else begin
      res.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
      res.bytes[1] = CONT_TAG | {2'b00, cp[17:12]};
      res.bytes[2] = CONT_TAG | {2'b00, cp[11:6]};
      res.bytes[3] = CONT_TAG | {2'b00, cp[5:0]};
      res.last     = 2'd3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/ceu_fifo.sv
// Small flip-flop queue between the front and back halves of the extractor.
// Generic over data width and depth; no package dependency.
`default_nettype none

module ceu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/ceu_front.sv
// Front half of the extractor: accepts cells, encodes them and keeps the line counters.
// Depends on ceu_pkg; pushes one job per byte-producing cell or line end.
`default_nettype none

module ceu_front
  import ceu_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              kind_i,
  input  wire logic [CP_W-1:0]   code_point_i,
  input  wire logic [POS_W-1:0]  row_in_line_i,
  input  wire logic [POS_W-1:0]  column_i,
  input  wire logic              wide_lead_i,
  input  wire logic              wide_trail_i,
  input  wire logic              queue_full_i,
  output logic                   push_o,
  output job_t                   job_o
);

  localparam int unsigned EXT_W = (COUNT_BITS > KEPT_W) ? COUNT_BITS : KEPT_W;

  logic [COUNT_BITS-1:0] emitted_q, emitted_d;
  logic [COUNT_BITS-1:0] kept_q, kept_d;
  logic [POS_W-1:0]      row_q, row_d;
  logic [POS_W-1:0]      col_q, col_d;
  logic [1:0]            width_q, width_d;

  logic                  accept;
  logic                  is_end;
  utf8_t                 enc;
  logic [2:0]            nbytes;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] emitted_add;
  logic                  nonblank;
  logic [EXT_W-1:0]      kept_ext;
  logic [KEPT_W-1:0]     kept_sat;
  logic                  line_blank;

  assign in_stall_o  = queue_full_i;
  assign accept      = in_valid_i & ~queue_full_i;
  assign is_end      = (kind_i == KIND_END);
  assign enc         = utf8_encode(code_point_i);
  assign nbytes      = {1'b0, enc.last} + 3'd1;
  assign sum         = {1'b0, emitted_q} + (COUNT_BITS + 1)'(nbytes);
  assign emitted_add = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign nonblank    = (code_point_i != CP_EMPTY) && (code_point_i != CP_SPACE);
  assign kept_ext    = EXT_W'(kept_q);
  assign kept_sat    = (kept_ext > EXT_W'(KEPT_MAX)) ? KEPT_MAX : kept_ext[KEPT_W-1:0];
  assign line_blank  = (kept_q == '0);

  // A trailing half of a wide glyph is taken but produces no job.
  assign push_o = accept & (is_end | ~wide_trail_i);

  always_comb begin
    job_o = '0;
    if (is_end) begin
      job_o.line_end = 1'b1;
      job_o.kept     = kept_sat;
      if (!line_blank) begin
        job_o.row = row_q;
        job_o.col = {1'b0, col_q} + COL_W'(width_q);
      end
    end else begin
      job_o.bytes = enc.bytes;
      job_o.last  = enc.last;
      job_o.row   = row_in_line_i;
      job_o.col   = {1'b0, column_i};
    end
  end

  always_comb begin
    emitted_d = emitted_q;
    kept_d    = kept_q;
    row_d     = row_q;
    col_d     = col_q;
    width_d   = width_q;
    if (accept) begin
      if (is_end) begin
        emitted_d = '0;
        kept_d    = '0;
        row_d     = '0;
        col_d     = '0;
        width_d   = 2'd1;
      end else if (!wide_trail_i) begin
        emitted_d = emitted_add;
        if (nonblank) begin
          kept_d  = emitted_add;
          row_d   = row_in_line_i;
          col_d   = column_i;
          width_d = wide_lead_i ? 2'd2 : 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q <= '0;
      kept_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      width_q   <= 2'd1;
    end else begin
      emitted_q <= emitted_d;
      kept_q    <= kept_d;
      row_q     <= row_d;
      col_q     <= col_d;
      width_q   <= width_d;
    end
  end

  a_kept_le_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= emitted_q)
    else $error("kept length exceeds emitted byte count");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_end) |=> (emitted_q == '0 && kept_q == '0 && width_q == 2'd1))
    else $error("line end did not clear the line state");

  a_width_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q == 2'd1 || width_q == 2'd2))
    else $error("last non-blank width out of range");

endmodule

`default_nettype wire

### sv/ceu_back.sv
// Back half of the extractor: serialises queued jobs into output beats.
// Depends on ceu_pkg; holds the output register that parts it from the receiver.
`default_nettype none

module ceu_back
  import ceu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire job_t               head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [BYTE_W-1:0]       text_byte_o,
  output logic [POS_W-1:0]        map_row_o,
  output logic [COL_W-1:0]        map_col_o,
  output logic                    line_end_o,
  output logic [KEPT_W-1:0]       kept_bytes_o
);

  logic              valid_q, valid_d;
  logic [1:0]        idx_q, idx_d;
  logic              load;
  logic [BYTE_W-1:0] byte_q;
  logic [POS_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              end_q;
  logic [KEPT_W-1:0] kept_q;

  // The output register takes a queued beat when it is empty or being drained.
  assign load  = head_valid_i & (~valid_q | ~out_stall_i);
  assign pop_o = load & (idx_q == head_i.last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = pop_o ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      row_q  <= head_i.row;
      col_q  <= head_i.col;
      end_q  <= head_i.line_end;
      kept_q <= head_i.kept;
    end
  end

  assign out_valid_o  = valid_q;
  assign text_byte_o  = byte_q;
  assign map_row_o    = row_q;
  assign map_col_o    = col_q;
  assign line_end_o   = end_q;
  assign kept_bytes_o = kept_q;

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("job popped from an empty queue");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q <= head_i.last))
    else $error("byte index ran past the end of the job");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && end_q) |-> (byte_q == '0))
    else $error("line-end beat carries a text byte");

endmodule

`default_nettype wire

### sv/cell_text_utf8_extractor.sv
// Top level of the cell text extractor: UTF-8 text with a per-byte position map.
// Depends on ceu_pkg, ceu_front, ceu_fifo and ceu_back.
//
// Usage: cells of one logical line arrive on the input channel (in_valid_i /
// in_stall_o), one per beat, ended by a beat with kind_i set. Each cell yields
// one to four output beats (out_valid_o / out_stall_i), one UTF-8 byte each,
// tagged with the cell's row and column; a wide-trail cell yields none. The
// line-end beat yields one closing beat with line_end_o set, the kept length
// in kept_bytes_o and the one-past-end position of the last non-blank cell.
// Path: an accepted beat is written into the job queue in the cycle it is taken;
// its output beats are then loaded into the output register in turn, from which
// the receiver takes them. The input takes one beat per cycle while the job
// queue has room; the output side moves one byte per cycle while the receiver
// does not stall, so a multi-byte glyph holds the back half until its last byte
// is loaded, and the queue absorbs short bursts of such glyphs.
// Reset clears the line counters, the queue and the output valid flag; no
// output beat is valid afterwards. When the receiver stalls, the output beat
// holds, the queue fills and in_stall_o rises once it is full.
`default_nettype none

module cell_text_utf8_extractor
  import ceu_pkg::*;
#(
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [CP_W-1:0]    code_point_i,
  input  wire logic [POS_W-1:0]   row_in_line_i,
  input  wire logic [POS_W-1:0]   column_i,
  input  wire logic               wide_lead_i,
  input  wire logic               wide_trail_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [BYTE_W-1:0]       text_byte_o,
  output logic [POS_W-1:0]        map_row_o,
  output logic [COL_W-1:0]        map_col_o,
  output logic                    line_end_o,
  output logic [KEPT_W-1:0]       kept_bytes_o
);

  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  job_t       push_job;
  job_t       head_job;
  logic [JOB_W-1:0] head_bits;

  ceu_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .code_point_i  (code_point_i),
    .row_in_line_i (row_in_line_i),
    .column_i      (column_i),
    .wide_lead_i   (wide_lead_i),
    .wide_trail_i  (wide_trail_i),
    .queue_full_i  (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  ceu_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_bits),
    .empty_o (empty)
  );

  assign head_job = job_t'(head_bits);

  ceu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (~empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .text_byte_o  (text_byte_o),
    .map_row_o    (map_row_o),
    .map_col_o    (map_col_o),
    .line_end_o   (line_end_o),
    .kept_bytes_o (kept_bytes_o)
  );

endmodule

`default_nettype wire
